// ===== design/firrs_pkg.sv =====
// Shared types, codes and widths for the FIR lowpass linear resampler.
`timescale 1ns / 1ps
`default_nettype none
package firrs_pkg;

  localparam int unsigned MAX_TAPS_DEF     = 255;
  localparam int unsigned SAMPLE_BITS_DEF  = 16;
  localparam int unsigned COEF_BITS_DEF    = 18;
  localparam int unsigned MAX_UPSAMPLE_DEF = 16;

  localparam int unsigned RATE_W   = 20;
  localparam int unsigned TCNT_W   = 8;
  localparam int unsigned TIDX_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned SKIP_W   = 24;

  localparam logic [RATE_W-1:0] IN_RATE_RST  = 20'd44100;
  localparam logic [RATE_W-1:0] OUT_RATE_RST = 20'd22050;
  localparam logic [TCNT_W-1:0] TAPS_RST     = 8'd127;

  typedef enum logic [CFG_AW-1:0] {
    REG_IN_RATE   = 2'd0,
    REG_OUT_RATE  = 2'd1,
    REG_TAP_COUNT = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_COEF   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_NONE   = 2'd3
  } item_kind_e;

  // Per-cycle commands to every cell of the delay chain.
  typedef struct packed {
    logic shift;
    logic rotate;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/firrs_cell.sv =====
// One delay-line cell: a sample and its coefficient, shifted or rotated along the row.
`timescale 1ns / 1ps
`default_nettype none
module firrs_cell #(
  parameter int unsigned SAMPLE_BITS = firrs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = firrs_pkg::COEF_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  firrs_pkg::cell_ctrl_t         ctrl_i,
  input  wire                           coef_we_i,
  input  wire signed [COEF_BITS-1:0]    coef_wdata_i,
  input  wire signed [SAMPLE_BITS-1:0]  shift_in_i,
  input  wire signed [SAMPLE_BITS-1:0]  rot_sample_i,
  input  wire signed [COEF_BITS-1:0]    rot_coef_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic signed [COEF_BITS-1:0]   coef_o
);
  import firrs_pkg::*;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [COEF_BITS-1:0]   coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (ctrl_i.clear) begin
      sample_q <= '0;
    end else if (ctrl_i.shift) begin
      sample_q <= shift_in_i;
    end else if (ctrl_i.rotate) begin
      sample_q <= rot_sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_we_i) begin
      coef_q <= coef_wdata_i;
    end else if (ctrl_i.rotate) begin
      coef_q <= rot_coef_i;
    end
  end

  assign sample_o = sample_q;
  assign coef_o   = coef_q;

endmodule
`default_nettype wire

// ===== design/firrs_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module firrs_div #(
  parameter int unsigned DVW = 37
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  wire [DVW-1:0]                   dividend_i,
  input  wire [firrs_pkg::RATE_W-1:0]     divisor_i,
  output logic                            done_o,
  output logic [DVW-1:0]                  quo_o,
  output logic [firrs_pkg::RATE_W-1:0]    rem_o
);
  import firrs_pkg::*;

  localparam int unsigned CW = $clog2(DVW + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVW-1:0]    quo_q, quo_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0] div_q, div_d;
  logic [RATE_W:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[DVW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = RATE_W'(trial - {1'b0, div_q});
        quo_d = {quo_q[DVW-2:0], 1'b1};
      end else begin
        rem_d = trial[RATE_W-1:0];
        quo_d = {quo_q[DVW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DVW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

`ifndef NO_ASSERTIONS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q)) else $error("divider remainder not below divisor");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

// ===== design/fir_lowpass_linear_resampler.sv =====
// Top level: FIR lowpass over a rotating cell chain, then linear interpolation resampling.
//
// Input words (s_axis) carry a kind in tuser: coefficient write, audio sample or
// trailing zero flush; tlast on a flush word marks the final flush of a stream.
// Output words (m_axis) carry resampled samples; tlast marks the last word that
// one input word causes. An input word causing no output gives no output word.
// Configuration (in_rate, out_rate, tap_count) is written through cfg_we_i; the user
// must write it only while the block is idle, as the block does not enforce this.
// A sample or flush word past priming rotates the cell row once around, with one
// multiply-accumulate unit at its head; then each output word and each rate fold
// uses the shared bit-serial divider. Priming words shift into the row unfiltered.
// One word is processed at a time; tready is high only between words.
// After reset the delay line and stream state are zero, coefficients are unset
// and the rates are 44100 and 22050 with 127 taps.
// When the receiver stalls, one word waits in the output register and one more
// in a hold register; processing then pauses until space frees up.
`timescale 1ns / 1ps
`default_nettype none
module fir_lowpass_linear_resampler #(
  parameter int unsigned MAX_TAPS     = firrs_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS  = firrs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS    = firrs_pkg::COEF_BITS_DEF,
  parameter int unsigned MAX_UPSAMPLE = firrs_pkg::MAX_UPSAMPLE_DEF,
  localparam int unsigned IN_DW  = ((SAMPLE_BITS + firrs_pkg::TIDX_W + COEF_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // audio_in, tap_index, tap_value (from bit 0 up), zero filled
  input  wire [IN_DW-1:0]                 s_axis_tdata,
  // kind
  input  wire [firrs_pkg::KIND_W-1:0]     s_axis_tuser,
  input  wire                             s_axis_tlast,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // audio_out, zero filled
  output logic [OUT_DW-1:0]               m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  input  wire                             cfg_we_i,
  input  wire [firrs_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  wire [firrs_pkg::RATE_W-1:0]     cfg_wdata_i
);
  import firrs_pkg::*;

  localparam int unsigned S     = SAMPLE_BITS;
  localparam int unsigned C     = COEF_BITS;
  localparam int unsigned TW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned KW    = $clog2(MAX_TAPS);
  localparam int unsigned ACC_W = S + C + $clog2(MAX_TAPS);
  localparam int unsigned DVW   = S + RATE_W + 1;
  localparam int unsigned PW    = S + RATE_W + 1;
  localparam int unsigned LIMIT = 2 * MAX_UPSAMPLE;
  localparam int unsigned NW    = $clog2(LIMIT + 1);
  localparam int unsigned CAPW  = RATE_W + $clog2(MAX_UPSAMPLE + 1);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_MAC   = 13'b0000000000010,
    ST_RND   = 13'b0000000000100,
    ST_FOLD  = 13'b0000000001000,
    ST_FOLDW = 13'b0000000010000,
    ST_CHK   = 13'b0000000100000,
    ST_MUL   = 13'b0000001000000,
    ST_SUM   = 13'b0000010000000,
    ST_DIVW  = 13'b0000100000000,
    ST_EMIT  = 13'b0001000000000,
    ST_PHW   = 13'b0010000000000,
    ST_POST  = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_e;

  // Input fields.
  logic signed [S-1:0] audio_in;
  logic [TIDX_W-1:0]   tap_index;
  logic signed [C-1:0] tap_value;
  item_kind_e          kind;
  assign audio_in  = s_axis_tdata[S-1:0];
  assign tap_index = s_axis_tdata[S+TIDX_W-1:S];
  assign tap_value = s_axis_tdata[S+TIDX_W+C-1:S+TIDX_W];
  assign kind      = item_kind_e'(s_axis_tuser);

  state_e state_q, state_d;

  logic [RATE_W-1:0] in_rate_q, out_rate_q;
  logic [TCNT_W-1:0] tap_count_q;

  logic [TW-1:0]     taps_q, taps_d, prime_q, prime_d;
  logic [RATE_W-1:0] inr_q, inr_d, outr_q, outr_d;
  logic              final_q, final_d;
  item_kind_e        kind_q, kind_d;
  logic [KW-1:0]     k_q, k_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [S-1:0] prev_q, prev_d, right_q, right_d, res_q, res_d;
  logic              have_q, have_d, flush_run_q, flush_run_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic [NW-1:0]     n_q, n_d;
  logic signed [PW-1:0] p1_q, p1_d, p2_q, p2_d;
  logic              neg_q, neg_d;
  logic signed [S-1:0] hold_q, hold_d;
  logic              hold_v_q, hold_v_d;
  logic [S-1:0]      out_q, out_d;
  logic              out_last_q, out_last_d, out_v_q, out_v_d;

  logic              in_acc, out_free, do_clear;
  cell_ctrl_t        cctrl;
  logic              div_start, div_done;
  logic [DVW-1:0]    div_dividend, div_quo;
  logic [RATE_W-1:0] div_rem;

  logic signed [S-1:0] cs [MAX_TAPS];
  logic signed [C-1:0] cc [MAX_TAPS];
  logic [MAX_TAPS-1:0] coef_we;
  logic signed [S-1:0] audio_in_x;

  // Effective settings taken at the start of a sample or flush word.
  logic [RATE_W-1:0] inr_eff, outr_raw;
  logic [CAPW-1:0]   cap;
  logic [TW-1:0]     taps_eff;

  always_comb begin
    inr_eff  = (in_rate_q == '0) ? RATE_W'(1) : in_rate_q;
    outr_raw = (out_rate_q == '0) ? RATE_W'(1) : out_rate_q;
    cap      = CAPW'(MAX_UPSAMPLE) * CAPW'(inr_eff);
    if (tap_count_q == '0) begin
      taps_eff = TW'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = TW'(tap_count_q);
    end
  end

  // Rounded, saturated filter output.
  logic [ACC_W:0]    mag, qr;
  logic signed [S-1:0] cur;
  always_comb begin
    mag = acc_q[ACC_W-1] ? (ACC_W+1)'(-acc_q) : (ACC_W+1)'(acc_q);
    qr  = (mag + ((ACC_W+1)'(1) << (C - 3))) >> (C - 2);
    if (acc_q[ACC_W-1]) begin
      if (qr > ((ACC_W+1)'(1) << (S - 1))) begin
        cur = {1'b1, {(S-1){1'b0}}};
      end else begin
        cur = S'(-qr);
      end
    end else begin
      if (qr > ((ACC_W+1)'(1) << (S - 1)) - 1'b1) begin
        cur = {1'b0, {(S-1){1'b1}}};
      end else begin
        cur = S'(qr);
      end
    end
  end

  logic signed [S+C-1:0] prod;
  logic signed [PW:0]    num;
  logic [PW:0]           num_mag;
  assign prod    = cs[0] * cc[0];
  assign num     = (PW+1)'(p1_q) + (PW+1)'(p2_q);
  assign num_mag = num[PW] ? (PW+1)'(-num) : (PW+1)'(num);

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_v_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    taps_d      = taps_q;
    prime_d     = prime_q;
    inr_d       = inr_q;
    outr_d      = outr_q;
    final_d     = final_q;
    kind_d      = kind_q;
    k_d         = k_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    right_d     = right_q;
    res_d       = res_q;
    have_d      = have_q;
    flush_run_d = flush_run_q;
    rem_d       = rem_q;
    skip_d      = skip_q;
    n_d         = n_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    neg_d       = neg_q;
    hold_d      = hold_q;
    hold_v_d    = hold_v_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_v_d     = out_v_q && !m_axis_tready;
    cctrl       = '0;
    do_clear    = 1'b0;
    div_start   = 1'b0;
    div_dividend = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind == KIND_SAMPLE || kind == KIND_FLUSH)) begin
          cctrl.shift = 1'b1;
          taps_d  = taps_eff;
          inr_d   = inr_eff;
          outr_d  = (CAPW'(outr_raw) > cap) ? RATE_W'(cap) : outr_raw;
          final_d = s_axis_tlast;
          kind_d  = kind;
          n_d     = '0;
          if (prime_q < (taps_eff >> 1)) begin
            prime_d = prime_q + 1'b1;
            state_d = ST_POST;
          end else begin
            acc_d   = '0;
            k_d     = '0;
            state_d = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cctrl.rotate = 1'b1;
        if (TW'(k_q) < taps_q) begin
          acc_d = acc_q + ACC_W'(prod);
        end
        k_d = k_q + 1'b1;
        if (k_q == KW'(MAX_TAPS - 1)) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        if (have_q) begin
          right_d     = cur;
          flush_run_d = 1'b0;
          state_d     = ST_FOLD;
        end else begin
          prev_d  = cur;
          have_d  = 1'b1;
          state_d = ST_POST;
        end
      end
      ST_FOLD: begin
        if (rem_q >= outr_q) begin
          div_start    = 1'b1;
          div_dividend = DVW'(rem_q);
          state_d      = ST_FOLDW;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_FOLDW: begin
        if (div_done) begin
          skip_d  = skip_q + div_quo[SKIP_W-1:0];
          rem_d   = div_rem;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (skip_q == '0 && n_q < NW'(LIMIT)) begin
          state_d = ST_MUL;
        end else if (flush_run_q) begin
          do_clear = 1'b1;
          state_d  = ST_DONE;
        end else begin
          if (skip_q != '0) begin
            skip_d = skip_q - 1'b1;
          end
          prev_d  = right_q;
          have_d  = 1'b1;
          state_d = ST_POST;
        end
      end
      ST_MUL: begin
        p1_d    = PW'(prev_q * $signed({1'b0, outr_q - rem_q}));
        p2_d    = PW'(right_q * $signed({1'b0, rem_q}));
        state_d = ST_SUM;
      end
      ST_SUM: begin
        neg_d        = num[PW];
        div_start    = 1'b1;
        div_dividend = DVW'(num_mag + (PW+1)'(outr_q >> 1));
        state_d      = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          res_d   = neg_q ? S'(-div_quo) : S'(div_quo);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!hold_v_q || out_free) begin
          if (hold_v_q) begin
            out_d      = hold_q;
            out_last_d = 1'b0;
            out_v_d    = 1'b1;
          end
          hold_d       = res_q;
          hold_v_d     = 1'b1;
          n_d          = n_q + 1'b1;
          div_start    = 1'b1;
          div_dividend = DVW'(rem_q) + DVW'(inr_q);
          state_d      = ST_PHW;
        end
      end
      ST_PHW: begin
        if (div_done) begin
          skip_d  = skip_q + div_quo[SKIP_W-1:0];
          rem_d   = div_rem;
          state_d = ST_CHK;
        end
      end
      ST_POST: begin
        if (kind_q == KIND_FLUSH && final_q) begin
          if (have_q) begin
            right_d     = prev_q;
            flush_run_d = 1'b1;
            state_d     = ST_FOLD;
          end else begin
            do_clear = 1'b1;
            state_d  = ST_DONE;
          end
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!hold_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d      = hold_q;
          out_last_d = 1'b1;
          out_v_d    = 1'b1;
          hold_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_clear) begin
      cctrl.clear = 1'b1;
      prime_d     = '0;
      prev_d      = '0;
      have_d      = 1'b0;
      rem_d       = '0;
      skip_d      = '0;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_rate_q   <= IN_RATE_RST;
      out_rate_q  <= OUT_RATE_RST;
      tap_count_q <= TAPS_RST;
      prime_q     <= '0;
      prev_q      <= '0;
      have_q      <= 1'b0;
      rem_q       <= '0;
      skip_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      flush_run_q <= 1'b0;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      prime_q     <= prime_d;
      prev_q      <= prev_d;
      have_q      <= have_d;
      rem_q       <= rem_d;
      skip_q      <= skip_d;
      n_q         <= n_d;
      k_q         <= k_d;
      flush_run_q <= flush_run_d;
      hold_v_q    <= hold_v_d;
      out_v_q     <= out_v_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_IN_RATE:   in_rate_q   <= cfg_wdata_i;
          REG_OUT_RATE:  out_rate_q  <= cfg_wdata_i;
          REG_TAP_COUNT: tap_count_q <= cfg_wdata_i[TCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    taps_q     <= taps_d;
    inr_q      <= inr_d;
    outr_q     <= outr_d;
    final_q    <= final_d;
    kind_q     <= kind_d;
    acc_q      <= acc_d;
    right_q    <= right_d;
    res_q      <= res_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    neg_q      <= neg_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign audio_in_x = (kind == KIND_SAMPLE) ? audio_in : '0;

  // Cell row: shift moves toward higher indexes, rotate moves the head along.
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    assign coef_we[i] = in_acc && (kind == KIND_COEF) && (32'(tap_index) == i);
    firrs_cell #(
      .SAMPLE_BITS(S),
      .COEF_BITS  (C)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cctrl),
      .coef_we_i   (coef_we[i]),
      .coef_wdata_i(tap_value),
      .shift_in_i  ((i == 0) ? audio_in_x : cs[(i + MAX_TAPS - 1) % MAX_TAPS]),
      .rot_sample_i(cs[(i + 1) % MAX_TAPS]),
      .rot_coef_i  (cc[(i + 1) % MAX_TAPS]),
      .sample_o    (cs[i]),
      .coef_o      (cc[i])
    );
  end

  firrs_div #(
    .DVW(DVW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (outr_q),
    .done_o    (div_done),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  assign m_axis_tdata  = OUT_DW'(out_q);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tvalid = out_v_q;

`ifndef NO_ASSERTIONS
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_v_q) else $error("held word left behind at idle");
  a_result_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(LIMIT)) else $error("too many results for one word");
  a_phase_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (rem_q < outr_q)) else $error("phase remainder not folded");
  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && hold_v_q && out_v_q && !m_axis_tready) |=> (state_q == ST_EMIT))
    else $error("result emitted without room");
`endif

endmodule
`default_nettype wire
